/* rtl/fpa_pkg.sv */
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic REG_FIT_POLICY      = 1'b0;
    localparam logic REG_PARTITION_COUNT = 1'b1;

    localparam logic [4:0] PCOUNT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  partition_index;
        logic [15:0] capacity_value;
        logic [15:0] request_size;
    } item_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_partition;
        logic [15:0] free_left;
    } result_t;

    typedef struct packed {
        logic [1:0] fit_policy;
        logic [4:0] partition_count;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPER,
        ST_SCAN,
        ST_WB
    } st_t;

endpackage

/* rtl/fpa_regs.sv */
`timescale 1ns / 1ps

module fpa_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpa_pkg::PADDR_W-1:0]     paddr,
    input  logic [fpa_pkg::PDATA_W-1:0]     pwdata,
    output logic [fpa_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output fpa_pkg::cfg_t                   cfg
);
    import fpa_pkg::*;

    logic [1:0] policy_reg;
    logic [4:0] pcount_reg;
    logic       wr_beat;

    assign wr_beat = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            pcount_reg <= PCOUNT_RESET;
        end
        else if (wr_beat)
        begin
            case (paddr[2])
                REG_FIT_POLICY:      policy_reg <= pwdata[1:0];
                REG_PARTITION_COUNT: pcount_reg <= pwdata[4:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIT_POLICY:      prdata = {{(PDATA_W-2){1'b0}}, policy_reg};
            REG_PARTITION_COUNT: prdata = {{(PDATA_W-5){1'b0}}, pcount_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.fit_policy      = policy_reg;
    assign cfg.partition_count = pcount_reg;

endmodule

/* rtl/fit_policy_partition_allocator.sv */
`timescale 1ns / 1ps

// Partition allocator with first, best or worst fit placement.
// Command channel: an item is taken on a clock edge with start high and busy low.
// busy stays high until its result has been shown. Results come on result,
// valid for exactly one cycle while done is high; there is no back-pressure.
// Config: APB port, fit_policy at 0x0, partition_count at 0x4, pready tied high.
// Write config only while busy is low.
// Set capacity, clear usage and no-op items give their result in the cycle
// after acceptance. An allocation reads the partition memory one entry per
// cycle through a three-deep pipeline (read, free space, compare), then writes
// back the chosen entry in the result cycle; with no partitions active, no
// entry is read.
// Capacity/usage live in one single-port-write synchronous memory; per-entry
// valid flops make it read as zero after reset, and clear-all resets the usage
// flags all together, so there is no clearing pass.
// Reset: tables read as zero, policy first fit, partition_count 16.
module fit_policy_partition_allocator #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpa_pkg::PADDR_W-1:0]     paddr,
    input  logic [fpa_pkg::PDATA_W-1:0]     pwdata,
    output logic [fpa_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            start,
    input  fpa_pkg::item_t                  item,
    output logic                            busy,
    output logic                            done,
    output fpa_pkg::result_t                result
);
    import fpa_pkg::*;

    localparam int ADDR_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(NUM_PARTITIONS + 1);

    cfg_t cfg;

    fpa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // entry = {capacity, used}
    logic [2*SIZE_BITS-1:0]  mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] ent_vld_reg;
    logic [NUM_PARTITIONS-1:0] used_vld_reg;

    st_t                 state_reg, state_next;
    item_t               item_reg;
    logic [CNT_W-1:0]    iss_reg;
    logic [CNT_W-1:0]    active;

    // stage A: memory read
    logic                a_vld_reg;
    logic [ADDR_W-1:0]   a_idx_reg;
    logic [2*SIZE_BITS-1:0] a_data_reg;
    logic                a_ev_reg;
    logic                a_uv_reg;

    // stage B: free space
    logic                b_vld_reg;
    logic [ADDR_W-1:0]   b_idx_reg;
    logic [SIZE_BITS-1:0] b_cap_reg;
    logic [SIZE_BITS-1:0] b_used_reg;
    logic [SIZE_BITS-1:0] b_free_reg;

    // stage C: running pick
    logic                found_reg;
    logic [ADDR_W-1:0]   pick_idx_reg;
    logic [SIZE_BITS-1:0] pick_cap_reg;
    logic [SIZE_BITS-1:0] pick_used_reg;
    logic [SIZE_BITS-1:0] pick_free_reg;

    logic                accept;
    logic                issue;
    logic                scan_end;
    logic [ADDR_W-1:0]   iss_addr;
    logic [SIZE_BITS-1:0] req_sz;
    logic [SIZE_BITS-1:0] a_cap;
    logic [SIZE_BITS-1:0] a_used;
    logic                fits;
    logic                better;
    logic                take;
    logic                in_range;
    logic                wr_en;
    logic                clr_all;
    logic [ADDR_W-1:0]   wr_addr;
    logic [2*SIZE_BITS-1:0] wr_data;
    logic                grant;

    always_comb
    begin
        if (32'(cfg.partition_count) > 32'(NUM_PARTITIONS))
            active = CNT_W'(NUM_PARTITIONS);
        else
            active = CNT_W'(cfg.partition_count);
    end

    assign accept   = start && (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && (iss_reg < active);
    assign scan_end = (state_reg == ST_SCAN) && !issue && !a_vld_reg && !b_vld_reg;
    assign iss_addr = iss_reg[ADDR_W-1:0];
    assign req_sz   = SIZE_BITS'(item_reg.request_size);
    assign in_range = 32'(item_reg.partition_index) < 32'(NUM_PARTITIONS);

    assign a_cap  = a_ev_reg ? a_data_reg[2*SIZE_BITS-1:SIZE_BITS] : '0;
    assign a_used = (a_ev_reg && a_uv_reg) ? a_data_reg[SIZE_BITS-1:0] : '0;

    always_comb
    begin
        case (cfg.fit_policy)
            POL_BEST:  better = b_free_reg < pick_free_reg;
            POL_WORST: better = b_free_reg > pick_free_reg;
            default:   better = 1'b0;
        endcase
    end

    assign fits = b_free_reg >= req_sz;
    assign take = b_vld_reg && fits && (!found_reg || better);

    // single write port: capacity set or allocation write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pick_idx_reg;
        wr_data = {pick_cap_reg, pick_used_reg + req_sz};
        if (state_reg == ST_OPER && item_reg.opcode == OP_SET && in_range)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(item_reg.partition_index);
            wr_data = {SIZE_BITS'(item_reg.capacity_value), {SIZE_BITS{1'b0}}};
        end
        else if (state_reg == ST_WB && found_reg)
        begin
            wr_en = 1'b1;
        end
    end

    assign clr_all = (state_reg == ST_OPER) && (item_reg.opcode == OP_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (item.opcode == OP_ALLOC) ? ST_SCAN : ST_OPER;
            end
            ST_OPER: state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_WB;
            end
            ST_WB:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy  = (state_reg != ST_IDLE);
        done  = (state_reg == ST_OPER) || (state_reg == ST_WB);
        grant = (state_reg == ST_WB) && found_reg;
        result.granted          = grant;
        result.chosen_partition = grant ? 4'(pick_idx_reg) : 4'd0;
        result.free_left        = grant ? 16'(pick_free_reg - req_sz) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_reg      <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            found_reg    <= 1'b0;
            ent_vld_reg  <= '0;
            used_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_vld_reg <= issue;
            b_vld_reg <= a_vld_reg;
            if (accept)
                iss_reg <= '0;
            else if (issue)
                iss_reg <= iss_reg + CNT_W'(1);
            if (accept)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
            if (clr_all)
                used_vld_reg <= '0;
            else if (wr_en)
                used_vld_reg[wr_addr] <= 1'b1;
            if (wr_en)
                ent_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue)
            a_data_reg <= mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (issue)
        begin
            a_idx_reg <= iss_addr;
            a_ev_reg  <= ent_vld_reg[iss_addr];
            a_uv_reg  <= used_vld_reg[iss_addr];
        end
        if (a_vld_reg)
        begin
            b_idx_reg  <= a_idx_reg;
            b_cap_reg  <= a_cap;
            b_used_reg <= a_used;
            b_free_reg <= (a_cap >= a_used) ? (a_cap - a_used) : '0;
        end
        if (take)
        begin
            pick_idx_reg  <= b_idx_reg;
            pick_cap_reg  <= b_cap_reg;
            pick_used_reg <= b_used_reg;
            pick_free_reg <= b_free_reg;
        end
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a busy period");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.granted) |->
            (result.chosen_partition == 4'd0 && result.free_left == 16'd0))
        else $error("refused result carries non-zero fields");

    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && found_reg) |->
            (32'(pick_idx_reg) < 32'(active) && pick_free_reg >= req_sz))
        else $error("write-back to partition that cannot hold the request");

endmodule
